### sv/pn_pkg.sv
package pn_pkg;

  // Fixed widths of the item fields and of the internal counters.
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 7;
  localparam int CLEN_W     = 8;
  localparam int POS_W      = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] DOT   = 8'h2E;

  localparam logic [LEN_W-1:0]  CAP_RESET   = 7'd64;
  localparam logic [CLEN_W-1:0] LIMIT_RESET = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT   = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIR,
    ST_FIRST,
    ST_TAKE,
    ST_END,
    ST_CLOSE,
    ST_POP,
    ST_FIN,
    ST_FAIL,
    ST_EMIT
  } state_t;

  // Commands to the component-start stack.
  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic [LEN_W-1:0] wdata;
  } stk_ctl_t;

  // Stack status; top is the entry read by the last pop, registered and valid in the cycle after the pop.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [LEN_W-1:0] top;
  } stk_stat_t;

endpackage

### sv/pn_if.sv
interface pn_in_if;
  logic                      valid;
  logic                      ready;
  logic [pn_pkg::CHAR_W-1:0] char_in;
  logic                      is_path;
  logic                      no_char;
  logic                      last_in;

  modport source (output valid, output char_in, output is_path, output no_char,
                  output last_in, input ready);
  modport sink   (input valid, input char_in, input is_path, input no_char,
                  input last_in, output ready);
endinterface

interface pn_out_if;
  logic                      valid;
  logic                      ready;
  logic [pn_pkg::CHAR_W-1:0] char_out;
  logic                      failed;
  logic                      last_out;

  modport source (output valid, output char_out, output failed, output last_out,
                  input ready);
  modport sink   (input valid, input char_out, input failed, input last_out,
                  output ready);
endinterface

interface pn_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pn_pkg::CFG_IDX_W-1:0]  index;
  logic [pn_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/pn_stack.sv
module pn_stack #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pn_pkg::stk_ctl_t  ctl,
  output pn_pkg::stk_stat_t stat
);

  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [pn_pkg::LEN_W-1:0] mem [STACK_DEPTH];
  logic [DW-1:0]            depth_r;
  logic [DW-1:0]            depth_nxt;
  logic [DW-1:0]            depth_dec;
  logic [pn_pkg::LEN_W-1:0] top_r;

  assign depth_dec = depth_r - DW'(1);

  always_comb begin
    depth_nxt = depth_r;
    if (ctl.clear) begin
      depth_nxt = '0;
    end else if (ctl.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (ctl.pop) begin
      depth_nxt = depth_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      mem[depth_r[SAW-1:0]] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      top_r <= mem[depth_dec[SAW-1:0]];
    end
  end

  assign stat.empty = (depth_r == '0);
  assign stat.full  = (depth_r == DW'(STACK_DEPTH));
  assign stat.top   = top_r;

endmodule

### sv/path_normalizer.sv
// Streaming Unix path canonicalizer.
// A run is a stream of byte items on in_ch: first the working directory
// (is_path low), then the requested path (is_path high), whose final item
// carries last_in. Relative paths are resolved on top of the working
// directory, "." is dropped and ".." removes the last component. Limits are
// set through cfg_ch: register 0 is the output capacity, register 1 the
// longest allowed component; the user must write both only while the block
// is idle, and the block does not enforce it. A working directory byte
// passes through DIR, a path byte through FIRST, TAKE and END; a close adds
// CLOSE, plus POP for ".." as the component-start stack is a memory with a
// registered read. The final item emits the normalized string on out_ch,
// one byte per item at one byte per cycle while out_ch.ready is high, with
// last_out on the final byte, or a single item with failed set. in_ch is not
// ready until the whole result has been handed to the output register. The
// output register holds its item while out_ch.ready is low; emission
// pauses and resumes without loss. Reset is synchronous and active low: it
// returns the sequencer to idle, empties the output register and restores
// the register defaults. The stores need no clearing pass after reset.
module path_normalizer #(
  parameter int BUFFER_BYTES = 64,
  parameter int STACK_DEPTH  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  pn_in_if.sink    in_ch,
  pn_out_if.source out_ch,
  pn_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam logic [pn_pkg::LEN_W-1:0] BUF_L = pn_pkg::LEN_W'(BUFFER_BYTES);

  // Sequencer state and the state to resume after a component close.
  pn_pkg::state_t state_r, state_nxt;
  pn_pkg::state_t ret_r, ret_nxt;
  logic           err_dir_r, err_dir_nxt;

  // Latched input item.
  logic [pn_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                      noc_r, noc_nxt;
  logic                      last_r, last_nxt;

  // Run state.
  logic [pn_pkg::LEN_W-1:0]  committed_r, committed_nxt;
  logic [pn_pkg::CLEN_W-1:0] comp_len_r, comp_len_nxt;
  logic                      only_dots_r, only_dots_nxt;
  logic                      dir_started_r, dir_started_nxt;
  logic                      dir_failed_r, dir_failed_nxt;
  logic                      path_started_r, path_started_nxt;
  logic                      path_failed_r, path_failed_nxt;

  // Configuration registers.
  logic [pn_pkg::LEN_W-1:0]  cap_r;
  logic [pn_pkg::CLEN_W-1:0] limit_r;

  // Emission.
  logic [pn_pkg::LEN_W-1:0]  idx_r, idx_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      rd_root_r, rd_root_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic                      rd_en;
  logic [pn_pkg::CHAR_W-1:0] rd_data_r;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic [pn_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                      out_failed_r, out_failed_nxt;
  logic                      out_last_r, out_last_nxt;

  // Path store write port.
  logic [pn_pkg::CHAR_W-1:0] path_mem [BUFFER_BYTES];
  logic                      st_we;
  logic [AW-1:0]             st_waddr;
  logic [pn_pkg::CHAR_W-1:0] st_wdata;

  pn_pkg::stk_ctl_t  stk_ctl;
  pn_pkg::stk_stat_t stk_stat;

  // Shared decode.
  logic                      in_acc;
  logic                      sep_w;
  logic [pn_pkg::POS_W-1:0]  pos_w;
  logic [pn_pkg::LEN_W-1:0]  cap_w;
  logic                      cap_low;
  logic                      is_slash;
  logic                      run_ok;
  logic                      take_ok;
  logic                      first_close;
  logic                      cl_skip;
  logic                      cl_dotdot;
  logic                      cl_pop;
  logic                      cl_fail;
  logic                      out_free;
  logic                      emit_issue;
  logic                      emit_done;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign sep_w    = (committed_r > pn_pkg::LEN_W'(1));
  // Staging position of the next byte; also the length after a commit.
  assign pos_w    = pn_pkg::POS_W'(committed_r) + pn_pkg::POS_W'(sep_w)
                  + pn_pkg::POS_W'(comp_len_r);
  assign cap_w    = (cap_r < BUF_L) ? cap_r : BUF_L;
  assign cap_low  = (cap_w < pn_pkg::LEN_W'(2));
  assign is_slash = (char_r == pn_pkg::SLASH);
  assign run_ok   = !dir_failed_r && !path_failed_r;
  assign take_ok  = !noc_r && run_ok;

  // A relative first path byte closes whatever the working directory left open.
  assign first_close = !path_started_r && dir_started_r && !noc_r && !is_slash && run_ok;

  assign cl_skip   = (comp_len_r == '0) ||
                     (only_dots_r && (comp_len_r == pn_pkg::CLEN_W'(1)));
  assign cl_dotdot = only_dots_r && (comp_len_r == pn_pkg::CLEN_W'(2));
  assign cl_pop    = !cl_skip && cl_dotdot && !stk_stat.empty;
  assign cl_fail   = (comp_len_r > limit_r) || cap_low ||
                     (pos_w >= pn_pkg::POS_W'(cap_w)) || stk_stat.full;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign emit_issue = (idx_r != committed_r) && (!rd_pend_r || out_free);
  assign emit_done  = (idx_r == committed_r) && !rd_pend_r;

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    err_dir_nxt = err_dir_r;
    case (state_r)
      pn_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_ch.is_path ? pn_pkg::ST_FIRST : pn_pkg::ST_DIR;
        end
      end
      pn_pkg::ST_DIR: begin
        state_nxt = pn_pkg::ST_IDLE;
        if (!path_started_r && dir_started_r && take_ok && is_slash) begin
          state_nxt   = pn_pkg::ST_CLOSE;
          ret_nxt     = pn_pkg::ST_IDLE;
          err_dir_nxt = 1'b1;
        end
      end
      pn_pkg::ST_FIRST: begin
        state_nxt = pn_pkg::ST_TAKE;
        if (first_close) begin
          state_nxt   = pn_pkg::ST_CLOSE;
          ret_nxt     = pn_pkg::ST_TAKE;
          err_dir_nxt = 1'b1;
        end
      end
      pn_pkg::ST_TAKE: begin
        state_nxt = pn_pkg::ST_END;
        if (take_ok && is_slash) begin
          state_nxt   = pn_pkg::ST_CLOSE;
          ret_nxt     = pn_pkg::ST_END;
          err_dir_nxt = 1'b0;
        end
      end
      pn_pkg::ST_END: begin
        if (!last_r) begin
          state_nxt = pn_pkg::ST_IDLE;
        end else if (run_ok) begin
          state_nxt   = pn_pkg::ST_CLOSE;
          ret_nxt     = pn_pkg::ST_FIN;
          err_dir_nxt = 1'b0;
        end else begin
          state_nxt = pn_pkg::ST_FIN;
        end
      end
      pn_pkg::ST_CLOSE: begin
        state_nxt = cl_pop ? pn_pkg::ST_POP : ret_r;
      end
      pn_pkg::ST_POP: begin
        state_nxt = ret_r;
      end
      pn_pkg::ST_FIN: begin
        state_nxt = (run_ok && !cap_low) ? pn_pkg::ST_EMIT : pn_pkg::ST_FAIL;
      end
      pn_pkg::ST_FAIL: begin
        if (out_free) begin
          state_nxt = pn_pkg::ST_IDLE;
        end
      end
      pn_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_nxt = pn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pn_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    char_nxt         = char_r;
    noc_nxt          = noc_r;
    last_nxt         = last_r;
    committed_nxt    = committed_r;
    comp_len_nxt     = comp_len_r;
    only_dots_nxt    = only_dots_r;
    dir_started_nxt  = dir_started_r;
    dir_failed_nxt   = dir_failed_r;
    path_started_nxt = path_started_r;
    path_failed_nxt  = path_failed_r;
    idx_nxt          = idx_r;
    rd_pend_nxt      = rd_pend_r;
    rd_root_nxt      = rd_root_r;
    rd_last_nxt      = rd_last_r;
    rd_en            = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_char_nxt     = out_char_r;
    out_failed_nxt   = out_failed_r;
    out_last_nxt     = out_last_r;
    st_we            = 1'b0;
    st_waddr         = pos_w[AW-1:0];
    st_wdata         = char_r;
    stk_ctl          = '0;
    stk_ctl.wdata    = committed_r;

    case (state_r)
      pn_pkg::ST_IDLE: begin
        if (in_acc) begin
          char_nxt = in_ch.char_in;
          noc_nxt  = in_ch.no_char || (in_ch.char_in == '0);
          last_nxt = in_ch.last_in;
        end
      end
      pn_pkg::ST_DIR: begin
        if (!path_started_r) begin
          if (!dir_started_r) begin
            // First byte of a run: start at root and check for a leading slash.
            committed_nxt   = pn_pkg::LEN_W'(1);
            comp_len_nxt    = '0;
            only_dots_nxt   = 1'b1;
            stk_ctl.clear   = 1'b1;
            dir_started_nxt = 1'b1;
            dir_failed_nxt  = 1'b0;
            path_failed_nxt = noc_r || !is_slash;
          end else if (take_ok && !is_slash) begin
            st_we         = (pos_w < pn_pkg::POS_W'(BUFFER_BYTES));
            comp_len_nxt  = (comp_len_r == '1) ? comp_len_r
                                               : comp_len_r + pn_pkg::CLEN_W'(1);
            only_dots_nxt = only_dots_r && (char_r == pn_pkg::DOT);
          end
        end
      end
      pn_pkg::ST_FIRST: begin
        if (!dir_started_r) begin
          // Path without a working directory: the run fails.
          committed_nxt   = pn_pkg::LEN_W'(1);
          comp_len_nxt    = '0;
          only_dots_nxt   = 1'b1;
          stk_ctl.clear   = 1'b1;
          dir_started_nxt = 1'b1;
          dir_failed_nxt  = 1'b0;
          path_failed_nxt = 1'b1;
        end
        if (!path_started_r) begin
          path_started_nxt = 1'b1;
          if (noc_r) begin
            path_failed_nxt = 1'b1;
          end else if (is_slash) begin
            // Absolute path: restart at root and forgive directory errors.
            committed_nxt  = pn_pkg::LEN_W'(1);
            comp_len_nxt   = '0;
            only_dots_nxt  = 1'b1;
            stk_ctl.clear  = 1'b1;
            dir_failed_nxt = 1'b0;
          end
        end
      end
      pn_pkg::ST_TAKE: begin
        if (take_ok && !is_slash) begin
          st_we         = (pos_w < pn_pkg::POS_W'(BUFFER_BYTES));
          comp_len_nxt  = (comp_len_r == '1) ? comp_len_r
                                             : comp_len_r + pn_pkg::CLEN_W'(1);
          only_dots_nxt = only_dots_r && (char_r == pn_pkg::DOT);
        end
      end
      pn_pkg::ST_CLOSE: begin
        comp_len_nxt  = '0;
        only_dots_nxt = 1'b1;
        if (cl_skip) begin
          // Empty or "." component: nothing to do.
        end else if (cl_dotdot) begin
          stk_ctl.pop = !stk_stat.empty;
        end else if (cl_fail) begin
          if (err_dir_r) begin
            dir_failed_nxt = 1'b1;
          end else begin
            path_failed_nxt = 1'b1;
          end
        end else begin
          // Commit the staged component behind a separator.
          stk_ctl.push  = 1'b1;
          st_we         = sep_w;
          st_waddr      = committed_r[AW-1:0];
          st_wdata      = pn_pkg::SLASH;
          committed_nxt = pos_w[pn_pkg::LEN_W-1:0];
        end
      end
      pn_pkg::ST_POP: begin
        committed_nxt = stk_stat.top;
      end
      pn_pkg::ST_FIN: begin
        if (cap_low) begin
          path_failed_nxt = 1'b1;
        end
        dir_started_nxt  = 1'b0;
        path_started_nxt = 1'b0;
        idx_nxt          = '0;
        rd_pend_nxt      = 1'b0;
      end
      pn_pkg::ST_FAIL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = '0;
          out_failed_nxt = 1'b1;
          out_last_nxt   = 1'b1;
        end
      end
      pn_pkg::ST_EMIT: begin
        if (rd_pend_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = rd_root_r ? pn_pkg::SLASH : rd_data_r;
          out_failed_nxt = 1'b0;
          out_last_nxt   = rd_last_r;
        end
        if (emit_issue) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + pn_pkg::LEN_W'(1);
          rd_root_nxt = (idx_r == '0);
          rd_last_nxt = ((idx_r + pn_pkg::LEN_W'(1)) == committed_r);
        end
        rd_pend_nxt = emit_issue || (rd_pend_r && !out_free);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pn_pkg::ST_IDLE;
      committed_r    <= pn_pkg::LEN_W'(1);
      comp_len_r     <= '0;
      only_dots_r    <= 1'b1;
      dir_started_r  <= 1'b0;
      dir_failed_r   <= 1'b0;
      path_started_r <= 1'b0;
      path_failed_r  <= 1'b0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      committed_r    <= committed_nxt;
      comp_len_r     <= comp_len_nxt;
      only_dots_r    <= only_dots_nxt;
      dir_started_r  <= dir_started_nxt;
      dir_failed_r   <= dir_failed_nxt;
      path_started_r <= path_started_nxt;
      path_failed_r  <= path_failed_nxt;
      rd_pend_r      <= rd_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    err_dir_r    <= err_dir_nxt;
    char_r       <= char_nxt;
    noc_r        <= noc_nxt;
    last_r       <= last_nxt;
    idx_r        <= idx_nxt;
    rd_root_r    <= rd_root_nxt;
    rd_last_r    <= rd_last_nxt;
    out_char_r   <= out_char_nxt;
    out_failed_r <= out_failed_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= pn_pkg::CAP_RESET;
      limit_r <= pn_pkg::LIMIT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        pn_pkg::REG_OUT_CAPACITY: cap_r   <= cfg_ch.data[pn_pkg::LEN_W-1:0];
        pn_pkg::REG_NAME_LIMIT:   limit_r <= cfg_ch.data[pn_pkg::CLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Path store. Entry zero is never written; the root slash is emitted in its place.
  always_ff @(posedge clk) begin
    if (st_we) begin
      path_mem[st_waddr] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= path_mem[idx_r[AW-1:0]];
    end
  end

  pn_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (stk_ctl),
    .stat (stk_stat)
  );

  assign in_ch.ready     = (state_r == pn_pkg::ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.failed   = out_failed_r;
  assign out_ch.last_out = out_last_r;

  // The committed length always covers the root and stays inside the store.
  a_committed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (committed_r != '0) && (committed_r < BUF_L))
    else $error("committed length out of range");

  // A pending store read only exists while emitting.
  a_read_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == pn_pkg::ST_EMIT))
    else $error("store read pending outside emission");

  // A failure result is a single zero byte that ends the run.
  a_fail_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_failed_r) |-> (out_last_r && (out_char_r == '0)))
    else $error("malformed failure item");

  // Emission never runs past the committed length.
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pn_pkg::ST_EMIT) |-> (idx_r <= committed_r))
    else $error("emission index past committed length");

  // The path phase of a run never begins without a working directory phase.
  a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
    path_started_r |-> dir_started_r)
    else $error("path started without a run");

endmodule
